/* rtl/led_pattern_sequencer_top_macros.svh */
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top_macros
// assertion macros used by the led pattern sequencer port checks
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_PATTERN_SEQUENCER_TOP_MACROS_SVH

// property checked only outside reset
`define LPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define LPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// types, constants and pattern functions of the led pattern sequencer
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int UNIT_W  = 16;
   localparam int TICK_W  = 19;
   localparam int LED_W   = 8;
   localparam int EFF_W   = 3;
   localparam int SPEED_W = 2;
   localparam int STEP_W  = 4;

   localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd50;

   // effect codes (effect number minus one)
   localparam logic [EFF_W-1:0] EFFECT_WALK     = 3'd0;
   localparam logic [EFF_W-1:0] EFFECT_CROSS    = 3'd1;
   localparam logic [EFF_W-1:0] EFFECT_FILL     = 3'd2;
   localparam logic [EFF_W-1:0] EFFECT_ENDS     = 3'd3;
   localparam logic [EFF_W-1:0] EFFECT_TRIPLE   = 3'd4;
   localparam logic [EFF_W-1:0] EFFECT_LAST     = EFFECT_TRIPLE;

   typedef enum logic [2:0] {
      PHASE_DWELL       = 3'b001,
      PHASE_SPEED_HOLD  = 3'b010,
      PHASE_EFFECT_HOLD = 3'b100
   } phase_type;

   // number of steps in each effect
   function automatic logic [STEP_W:0] steps_of(input logic [EFF_W-1:0] eff);
      logic [STEP_W:0] n;
      unique case (eff)
         EFFECT_WALK:   n = 5'd8;
         EFFECT_CROSS:  n = 5'd8;
         EFFECT_FILL:   n = 5'd9;
         EFFECT_ENDS:   n = 5'd5;
         EFFECT_TRIPLE: n = 5'd9;
         default:       n = 5'd8;
      endcase
      return n;
   endfunction

   // pattern shown for one step of one effect
   function automatic logic [LED_W-1:0] led_of(input logic [EFF_W-1:0]  eff,
                                              input logic [STEP_W-1:0] s);
      logic [15:0]      one_bit;
      logic [15:0]      triple;
      logic [LED_W-1:0] mirror;
      logic [LED_W-1:0] v;
      one_bit = 16'd1 << s;
      triple  = (16'd3 << s) - 16'd1;
      mirror  = 8'd1 << (3'd7 - s[2:0]);
      unique case (eff)
         EFFECT_WALK:  v = s[3] ? 8'h00 : one_bit[7:0];
         EFFECT_CROSS: v = s[3] ? 8'h00 : (one_bit[7:0] | mirror);
         EFFECT_FILL:  v = s[3] ? 8'hFF : 8'(one_bit - 16'd1);
         EFFECT_ENDS: begin
            case (s)
               4'd0:    v = 8'h00;
               4'd1:    v = 8'h81;
               4'd2:    v = 8'hC3;
               4'd3:    v = 8'hE7;
               default: v = 8'hFF;
            endcase
         end
         default:      v = triple[7:0];
      endcase
      return v;
   endfunction

endpackage

/* rtl/led_pattern_sequencer_top.sv */
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top
// five-effect led chaser driven by one timer tick per input transfer
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per timer tick, carrying the two button levels.
//   rsp channel: one transfer per req transfer, carrying the led pattern that
//   was on during that tick (before the tick moves the sequence on).
//   csr channel: writes unit_ticks, the ticks in one delay unit (0 acts as 1);
//   csr_ready is always high, write only while no transfer is in flight.
// Result: registered, valid in the cycle after its req transfer.
// Throughput: one tick per cycle unless stalled; the whole step update is a single pass of
//   logic (19-bit increment and compare) between the state and the output
//   register.
// Stall: req_ready drops only while a result sits in the output register and
//   rsp_ready is low; the result and the sequence state then hold.
// Reset: effect 1, speed 1, step 0, dwell phase, unit_ticks 50, no result.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_effect_button,
   input  logic        req_speed_button,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_led_pattern,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_unit_ticks
);

   logic [lps_pkg::UNIT_W-1:0]  unit_ff;
   logic [lps_pkg::EFF_W-1:0]   effect_ff, effect_in;
   logic [lps_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [lps_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [lps_pkg::TICK_W-1:0]  tick_ff, tick_in;
   lps_pkg::phase_type          phase_ff, phase_in;
   logic                        rsp_valid_ff;
   logic [lps_pkg::LED_W-1:0]   led_ff;

   logic                        req_fire;
   logic [lps_pkg::TICK_W-1:0]  tick_inc;
   logic [lps_pkg::UNIT_W-1:0]  unit_len;
   logic [lps_pkg::TICK_W-1:0]  unit_len_ext;
   logic [lps_pkg::TICK_W-1:0]  dwell_len;
   logic                        last_step;
   logic [lps_pkg::STEP_W-1:0]  es_step;
   lps_pkg::phase_type          es_phase;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_pattern = led_ff;

   assign tick_inc     = tick_ff + 19'd1;
   assign unit_len     = (unit_ff == '0) ? 16'd1 : unit_ff;
   assign unit_len_ext = {3'b000, unit_len};
   assign dwell_len    = unit_len_ext << speed_ff;
   assign last_step    = ({1'b0, step_ff} + 5'd1) >= lps_pkg::steps_of(effect_ff);

   // outcome of finishing a step
   always_comb begin
      if (!last_step) begin
         es_step  = step_ff + 4'd1;
         es_phase = lps_pkg::PHASE_DWELL;
      end else if (req_effect_button) begin
         es_step  = step_ff;
         es_phase = lps_pkg::PHASE_EFFECT_HOLD;
      end else begin
         es_step  = '0;
         es_phase = lps_pkg::PHASE_DWELL;
      end
   end

   always_comb begin
      effect_in = effect_ff;
      speed_in  = speed_ff;
      step_in   = step_ff;
      tick_in   = tick_inc;
      phase_in  = phase_ff;
      unique case (phase_ff)
         lps_pkg::PHASE_DWELL: begin
            if (tick_inc >= dwell_len) begin
               tick_in = '0;
               if (req_speed_button) begin
                  phase_in = lps_pkg::PHASE_SPEED_HOLD;
               end else begin
                  step_in  = es_step;
                  phase_in = es_phase;
               end
            end
         end
         lps_pkg::PHASE_SPEED_HOLD: begin
            if (tick_inc >= unit_len_ext) begin
               speed_in = speed_ff + 2'd1;
               tick_in  = '0;
               step_in  = es_step;
               phase_in = es_phase;
            end
         end
         lps_pkg::PHASE_EFFECT_HOLD: begin
            if (tick_inc >= unit_len_ext) begin
               effect_in = (effect_ff == lps_pkg::EFFECT_LAST) ? lps_pkg::EFFECT_WALK
                                                               : effect_ff + 3'd1;
               step_in   = '0;
               tick_in   = '0;
               phase_in  = lps_pkg::PHASE_DWELL;
            end
         end
         default: begin
            tick_in  = '0;
            phase_in = lps_pkg::PHASE_DWELL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff      <= lps_pkg::UNIT_TICKS_RESET;
         effect_ff    <= lps_pkg::EFFECT_WALK;
         speed_ff     <= '0;
         step_ff      <= '0;
         tick_ff      <= '0;
         phase_ff     <= lps_pkg::PHASE_DWELL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unit_ff <= csr_unit_ticks;
         end
         if (req_fire) begin
            effect_ff    <= effect_in;
            speed_ff     <= speed_in;
            step_ff      <= step_in;
            tick_ff      <= tick_in;
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pattern of the tick being taken, before its update
   always_ff @(posedge clock) begin
      if (req_fire) begin
         led_ff <= lps_pkg::led_of(effect_ff, step_ff);
      end
   end

endmodule

/* rtl/lps_checker.sv */
// ----------------------------------------------------------------------------
// lps_checker
// port-level checks of the led pattern sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "led_pattern_sequencer_top_macros.svh"

module lps_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_led_pattern
);

   // a stalled result holds its value
   `LPS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_pattern), "stalled result changed")

   // every req transfer gives a result in the next cycle
   `LPS_ASSERT(a_req_to_rsp, clock, reset, req_valid && req_ready |=> rsp_valid, "req transfer without result")

   // an empty output register never blocks the input
   `LPS_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "input blocked while output empty")

   // reset leaves no result pending
   `LPS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind led_pattern_sequencer_top lps_port_checks u_lps_port_checks (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_led_pattern (rsp_led_pattern)
);

/* sim/lps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_checker
// watches the req, rsp and csr channels of the led pattern sequencer, tracks
// effect, speed, step and dwell timing on its own and compares every rsp
// transfer with the pattern it predicts for the matching tick
// ----------------------------------------------------------------------------
module lps_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_effect_button,
   input  logic        req_speed_button,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_led_pattern,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_unit_ticks,
   output int          pending,
   output int          fail_count
);

   logic [15:0]         unit_ticks_q;
   logic [2:0]          effect_q;
   logic [1:0]          speed_q;
   logic [3:0]          step_q;
   logic [18:0]         ticks_q;
   lps_pkg::phase_type  phase_q;
   logic [7:0]          led_expected [$];

   function automatic logic [7:0] pattern_for(input logic [2:0] eff, input logic [3:0] s);
      logic [31:0] w;
      case (eff)
         lps_pkg::EFFECT_WALK:  w = (s < 4'd8) ? (32'd1 << s) : 32'd0;
         lps_pkg::EFFECT_CROSS: w = (s < 4'd8) ? ((32'd1 << s) | (32'd1 << (4'd7 - s)))
                                               : 32'd0;
         lps_pkg::EFFECT_FILL:  w = (32'd1 << s) - 32'd1;
         lps_pkg::EFFECT_ENDS: begin
            case (s)
               4'd0:    w = 32'h00;
               4'd1:    w = 32'h81;
               4'd2:    w = 32'hC3;
               4'd3:    w = 32'hE7;
               default: w = 32'hFF;
            endcase
         end
         default:      w = (32'd3 << s) - 32'd1;
      endcase
      return w[7:0];
   endfunction

   function automatic logic [4:0] steps_in(input logic [2:0] eff);
      case (eff)
         lps_pkg::EFFECT_FILL, lps_pkg::EFFECT_TRIPLE: return 5'd9;
         lps_pkg::EFFECT_ENDS:                         return 5'd5;
         default:                                      return 5'd8;
      endcase
   endfunction

   // steps on; the last step parks in the effect hold or wraps to step 0
   task automatic close_step(input logic eff_btn);
      ticks_q = '0;
      if ({1'b0, step_q} + 5'd1 < steps_in(effect_q)) begin
         step_q  = step_q + 4'd1;
         phase_q = lps_pkg::PHASE_DWELL;
      end else if (eff_btn) begin
         phase_q = lps_pkg::PHASE_EFFECT_HOLD;
      end else begin
         step_q  = '0;
         phase_q = lps_pkg::PHASE_DWELL;
      end
   endtask

   always @(posedge clock) begin : predict
      logic [7:0]  want;
      logic [19:0] unit_len;
      if (reset) begin
         unit_ticks_q = lps_pkg::UNIT_TICKS_RESET;
         effect_q     = lps_pkg::EFFECT_WALK;
         speed_q      = '0;
         step_q       = '0;
         ticks_q      = '0;
         phase_q      = lps_pkg::PHASE_DWELL;
         led_expected.delete();
      end else begin
         // compare before queuing this edge's tick
         if (rsp_valid && rsp_ready) begin
            if (led_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: led_pattern %02h", rsp_led_pattern);
            end else begin
               want = led_expected.pop_front();
               if (want !== rsp_led_pattern) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: led_pattern expected %02h got %02h",
                              want, rsp_led_pattern);
               end
            end
         end
         if (csr_valid && csr_ready)
            unit_ticks_q = csr_unit_ticks;
         if (req_valid && req_ready) begin
            led_expected.push_back(pattern_for(effect_q, step_q));
            ticks_q  = ticks_q + 19'd1;
            unit_len = (unit_ticks_q == 16'd0) ? 20'd1 : {4'd0, unit_ticks_q};
            case (phase_q)
               lps_pkg::PHASE_DWELL: begin
                  if ({1'b0, ticks_q} >= (unit_len << speed_q)) begin
                     if (req_speed_button) begin
                        ticks_q = '0;
                        phase_q = lps_pkg::PHASE_SPEED_HOLD;
                     end else begin
                        close_step(req_effect_button);
                     end
                  end
               end
               lps_pkg::PHASE_SPEED_HOLD: begin
                  if ({1'b0, ticks_q} >= unit_len) begin
                     speed_q = speed_q + 2'd1;
                     close_step(req_effect_button);
                  end
               end
               default: begin
                  if ({1'b0, ticks_q} >= unit_len) begin
                     effect_q = (effect_q == lps_pkg::EFFECT_LAST) ? lps_pkg::EFFECT_WALK
                                                                   : effect_q + 3'd1;
                     step_q   = '0;
                     ticks_q  = '0;
                     phase_q  = lps_pkg::PHASE_DWELL;
                  end
               end
            endcase
         end
      end
      pending <= led_expected.size();
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives button ticks and unit_ticks writes into the led pattern sequencer
// with random gaps and stalls, over small, zero and extreme delay units
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic        req_effect_button = 1'b0;
   logic        req_speed_button  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [7:0]  rsp_led_pattern;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_unit_ticks    = 16'd0;

   int   pending;
   int   fail_count;
   int   cycles = 0;
   logic quiet  = 1'b0;

   always #5 clock = ~clock;

   led_pattern_sequencer_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_effect_button (req_effect_button),
      .req_speed_button  (req_speed_button),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_pattern   (rsp_led_pattern),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_unit_ticks    (csr_unit_ticks)
   );

   lps_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_effect_button (req_effect_button),
      .req_speed_button  (req_speed_button),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_pattern   (rsp_led_pattern),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_unit_ticks    (csr_unit_ticks),
      .pending           (pending),
      .fail_count        (fail_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stall before each rsp transfer
   initial begin : receiver
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_tick(input logic eff_level, input logic spd_level);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_effect_button <= eff_level;
      req_speed_button  <= spd_level;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every tick has produced its pattern
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_unit(input logic [15:0] ticks);
      wait_for_results();
      csr_valid      <= 1'b1;
      csr_unit_ticks <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      // {effect, speed} levels for the opening ticks
      logic [1:0]  opening [0:23];
      logic [15:0] units [0:11];
      logic        eff;
      logic        spd;
      int          n;
      opening = '{2'b00, 2'b01, 2'b10, 2'b11,
                  2'b01, 2'b00, 2'b11, 2'b11, 2'b10, 2'b10,
                  2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10,
                  2'b10, 2'b10, 2'b01, 2'b00, 2'b00, 2'b11,
                  2'b10, 2'b00};
      units   = '{16'd1, 16'd2, 16'hFFFF, 16'd1, 16'd0, 16'd3,
                  16'd0, 16'd1, 16'd4, 16'd2, 16'd1, 16'd5};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default unit: buttons are ignored away from a dwell end
      for (int i = 0; i < 4; i++)
         send_tick(opening[i][1], opening[i][0]);
      // zero unit acts as one tick per unit
      set_unit(16'd0);
      for (int i = 4; i < 24; i++)
         send_tick(opening[i][1], opening[i][0]);

      units[6] = 16'($urandom_range(9, 65534));
      eff = 1'b0;
      spd = 1'b0;
      for (int k = 0; k < 12; k++) begin
         // a large unit leaves the step mid-dwell for the next, smaller unit
         set_unit(units[k]);
         quiet = ($urandom_range(0, 3) == 0);
         n = (units[k] > 16'd8) ? 12 : 50;
         repeat (n) begin
            if ($urandom_range(0, 2) == 0) eff = ~eff;
            if ($urandom_range(0, 2) == 0) spd = ~spd;
            if ($urandom_range(0, 59) == 0) wait_for_results();
            send_tick(eff, spd);
         end
      end

      wait_for_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
